/* hdl/tgr_pkg.sv */
`timescale 1ns / 1ps
package tgr_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int TotW      = $clog2(MaxPoints + 1);
  localparam logic [16:0] FullDrive = 17'd65536;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  localparam logic [0:0] RegDrive = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [24:0] envelope;
    logic [23:0] point_command;
    logic [23:0] point_reduction;
  } in_word_t;

  typedef struct packed {
    logic [23:0] command_volts;
    logic [23:0] reduction_db;
    logic [31:0] sample_index;
    logic        table_usable;
    logic        status;
  } out_word_t;

endpackage

/* hdl/tgr_stream_if.sv */
`timescale 1ns / 1ps
interface tgr_in_if;
  import tgr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgr_out_if;
  import tgr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/table_gain_reduction_interp.sv */
`timescale 1ns / 1ps
// Limiter gain-reduction table with piecewise linear interpolation.
// in_if carries words with an opcode: clear, append breakpoint, evaluate or none.
// out_if returns exactly one word per input word. Both are valid/ready.
// The drive register (Q1.16) sits at APB byte address 0; pready is tied high.
// Breakpoints live in a 64-entry synchronous RAM (command and reduction
// packed in one 48-bit row), read one entry per cycle.
// Clear and opcode 3 answer straight from idle; append reads the last point
// from the RAM, then checks it. Evaluate does one scale multiply; without a
// usable table it answers then, else it reads both end points and answers
// when the command lands on or outside the table, else it goes on: up to
// six binary-search probes (a read and a compare each), two segment reads,
// a 24x24 multiply and a bit-serial divide. One word is in flight at a time
// and a new word is taken the cycle after the result leaves.
// The result waits in an output register while out_if.ready is low; the
// block does not take a new word until that result leaves.
// Reset clears the table count, the flaw flag, the counter and sets the
// drive to full; the RAM contents need no clearing.
module table_gain_reduction_interp (
  input  logic        clk_i,
  input  logic        rst_ni,
  tgr_in_if.sink      in_if,
  tgr_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tgr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_APPRD  = 12'b000000000010,
    S_APPCHK = 12'b000000000100,
    S_SCALE  = 12'b000000001000,
    S_RDFIRST= 12'b000000010000,
    S_RDLAST = 12'b000000100000,
    S_ENDS   = 12'b000001000000,
    S_PROBE  = 12'b000010000000,
    S_PCHK   = 12'b000100000000,
    S_SEG    = 12'b001000000000,
    S_MUL    = 12'b010000000000,
    S_DIV    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // breakpoint RAM
  logic [47:0]     mem [MaxPoints];
  logic            mem_we;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic [47:0]     mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  logic [16:0]     drive_q;
  logic [TotW-1:0] total_q, total_d;
  logic            flawed_q, flawed_d;
  logic [31:0]     count_q, count_d;
  in_word_t        in_q, in_d;
  out_word_t       out_q, out_d;
  logic            ovalid_q, ovalid_d;
  logic [23:0]     cmd_q, cmd_d, first_c_q, first_c_d, first_r_q, first_r_d;
  logic [23:0]     left_c_q, left_c_d, left_r_q, left_r_d;
  logic [TotW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [47:0]     prod_q, prod_d;
  logic            neg_q, neg_d, usable_q, usable_d;
  logic            div_start, div_done;
  logic [48:0]     div_quot;
  logic [23:0]     dx_q, dx_d;
  logic [41:0]     scaled;
  logic [18:0]     scale;
  logic [TotW-1:0] mid;
  logic [24:0]     dy;
  logic [23:0]     dy_mag;
  logic [24:0]     dxc;
  logic [49:0]     sum;
  logic            env_pos;

  tgr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .neg_i  (neg_q),
    .num_i  (prod_q),
    .den_i  (dx_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {15'd0, drive_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= FullDrive;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      drive_q <= pwdata[16:0];
    end
  end

  assign in_if.ready  = (state_q == S_IDLE) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = out_q;

  assign scale   = 19'd65536 + 19'd3 * ((drive_q > FullDrive) ? {2'b0, FullDrive} : {2'b0, drive_q});
  assign scaled  = {18'd0, in_q.envelope[23:0]} * {23'd0, scale};
  assign env_pos = !in_q.envelope[24] && (in_q.envelope != '0);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign dy      = {1'b0, mem_rd_q[23:0]} - {1'b0, left_r_q};
  assign dy_mag  = dy[24] ? (~dy[23:0] + 24'd1) : dy[23:0];
  assign dxc     = {1'b0, mem_rd_q[47:24]} - {1'b0, left_c_q};
  assign sum     = {{26{1'b0}}, left_r_q} + {div_quot[48], div_quot};

  // main sequencer
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    flawed_d  = flawed_q;
    count_d   = count_q;
    in_d      = in_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q;
    cmd_d     = cmd_q;
    first_c_d = first_c_q;
    first_r_d = first_r_q;
    left_c_d  = left_c_q;
    left_r_d  = left_r_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    dx_d      = dx_q;
    usable_d  = usable_q;
    mem_we    = 1'b0;
    mem_wa    = total_q[IdxW-1:0];
    mem_wd    = {in_q.point_command, in_q.point_reduction};
    mem_ra    = '0;
    div_start = 1'b0;
    if (ovalid_q && out_if.ready) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          in_d = in_if.data;
          out_d = '0;
          usable_d = (total_q >= TotW'(2)) && !flawed_q;
          case (opcode_e'(in_if.data.opcode))
            OP_CLEAR: begin
              total_d = '0;
              flawed_d = 1'b0;
              count_d = '0;
              out_d.sample_index = '0;
              ovalid_d = 1'b1;
            end
            OP_APPEND: begin
              mem_ra = total_q[IdxW-1:0] - IdxW'(1);
              state_d = S_APPRD;
            end
            OP_EVAL: begin
              count_d = count_q + 32'd1;
              state_d = S_SCALE;
            end
            default: begin
              out_d.sample_index = count_q;
              out_d.table_usable = (total_q >= TotW'(2)) && !flawed_q;
              ovalid_d = 1'b1;
            end
          endcase
        end
      end
      S_APPRD: begin
        // hold the read of the last point
        mem_ra = total_q[IdxW-1:0] - IdxW'(1);
        state_d = S_APPCHK;
      end
      S_APPCHK: begin
        if (total_q >= TotW'(MaxPoints) ||
            (total_q != '0 && (!(in_q.point_command > mem_rd_q[47:24]) ||
             ({1'b0, in_q.point_reduction} + 25'd1 < {1'b0, mem_rd_q[23:0]})))) begin
          flawed_d = 1'b1;
          out_d.status = 1'b1;
          out_d.table_usable = 1'b0;
        end else begin
          mem_we = 1'b1;
          total_d = total_q + TotW'(1);
          out_d.table_usable = (total_q + TotW'(1) >= TotW'(2)) && !flawed_q;
        end
        out_d.sample_index = count_q;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SCALE: begin
        if (env_pos) begin
          cmd_d = scaled[41:18];
        end else begin
          cmd_d = '0;
        end
        mem_ra = '0;
        state_d = usable_q ? S_RDFIRST : S_ENDS;
      end
      S_RDFIRST: begin
        // first point is on the read port; clamp a positive command below it
        first_c_d = mem_rd_q[47:24];
        first_r_d = mem_rd_q[23:0];
        if (env_pos && cmd_q < mem_rd_q[47:24]) cmd_d = mem_rd_q[47:24];
        mem_ra = total_q[IdxW-1:0] - IdxW'(1);
        state_d = S_RDLAST;
      end
      S_RDLAST: begin
        // keep the last point on the read port for the span check
        mem_ra = total_q[IdxW-1:0] - IdxW'(1);
        state_d = S_ENDS;
      end
      S_ENDS: begin
        out_d.sample_index = count_q;
        out_d.table_usable = usable_q;
        out_d.command_volts = cmd_q;
        state_d = S_IDLE;
        if (!usable_q) begin
          ovalid_d = 1'b1;
        end else if (cmd_q <= first_c_q) begin
          out_d.reduction_db = first_r_q;
          ovalid_d = 1'b1;
        end else if (cmd_q >= mem_rd_q[47:24]) begin
          out_d.command_volts = mem_rd_q[47:24];
          out_d.reduction_db = mem_rd_q[23:0];
          ovalid_d = 1'b1;
        end else begin
          lo_d = TotW'(1);
          hi_d = total_q - TotW'(1);
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mem_ra = mid[IdxW-1:0];
          state_d = S_PCHK;
        end else begin
          mem_ra = lo_q[IdxW-1:0] - IdxW'(1);
          state_d = S_SEG;
        end
      end
      S_PCHK: begin
        if (mem_rd_q[47:24] < cmd_q) lo_d = mid + TotW'(1);
        else hi_d = mid;
        state_d = S_PROBE;
        if (!(lo_q < hi_q)) state_d = S_PROBE;
      end
      S_SEG: begin
        left_c_d = mem_rd_q[47:24];
        left_r_d = mem_rd_q[23:0];
        mem_ra = lo_q[IdxW-1:0];
        state_d = S_MUL;
      end
      S_MUL: begin
        neg_d  = dy[24];
        prod_d = {24'd0, dy_mag} * {24'd0, cmd_q - left_c_q};
        dx_d   = dxc[23:0];
        state_d = S_DIV;
        lo_d   = '0;
      end
      S_DIV: begin
        if (lo_q == '0) begin
          div_start = 1'b1;
          lo_d = TotW'(1);
        end else if (div_done) begin
          out_d.reduction_db = sum[49] ? 24'd0 :
                               (sum[48:24] != '0 ? 24'hFFFFFF : sum[23:0]);
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      flawed_q <= 1'b0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      flawed_q <= flawed_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    out_q     <= out_d;
    cmd_q     <= cmd_d;
    first_c_q <= first_c_d;
    first_r_q <= first_r_d;
    left_c_q  <= left_c_d;
    left_r_q  <= left_r_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    dx_q      <= dx_d;
    usable_q  <= usable_d;
  end

  // checks
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotW'(MaxPoints)) else $error("table count overflow");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_if.ready) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_if.ready |=> ovalid_q && $stable(out_q)) else $error("result lost");
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> total_q < TotW'(MaxPoints)) else $error("write past table end");

endmodule

/* hdl/tgr_divider.sv */
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// Dividend 49 bits signed magnitude-wise, divisor 24 bits positive.
module tgr_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        neg_i,
  input  logic [47:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [48:0] quot_o
);
  logic [47:0] quo_q, quo_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [24:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd47;
      busy_d = 1'b1;
      neg_d  = neg_i;
    end else if (busy_q) begin
      trial = {rem_q[23:0], quo_q[47]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};

endmodule

/* tb/sv/table_gain_reduction_interp_tb.sv */
`timescale 1ns / 1ps
module table_gain_reduction_interp_tb;
  import tgr_pkg::*;

  // gain-reduction table model and queue of expected result words
  class gain_table_board;
    logic [23:0] cmd_tab[MaxPoints];
    logic [23:0] red_tab[MaxPoints];
    int unsigned npts;
    bit          flawed;
    logic [31:0] evals;
    logic [16:0] drive;
    out_word_t   pending[$];
    int          mismatches;

    function void reset_state();
      npts = 0;
      flawed = 0;
      evals = 0;
      drive = FullDrive;
      pending.delete();
      mismatches = 0;
    endfunction

    function logic [23:0] interp(logic [23:0] c);
      int unsigned lo, hi, mid, lft;
      longint dx, dy, num, q, r;
      if (c <= cmd_tab[0]) return red_tab[0];
      if (c >= cmd_tab[npts-1]) return red_tab[npts-1];
      lo = 1;
      hi = npts - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (cmd_tab[mid] < c) lo = mid + 1;
        else hi = mid;
      end
      lft = lo - 1;
      dx = longint'(cmd_tab[lo]) - longint'(cmd_tab[lft]);
      if (dx <= 0) return red_tab[lft];
      dy = longint'(red_tab[lo]) - longint'(red_tab[lft]);
      num = dy * (longint'(c) - longint'(cmd_tab[lft]));
      q = num / dx;
      r = longint'(red_tab[lft]) + q;
      if (r < 0) r = 0;
      if (r > 64'hFFFFFF) r = 64'hFFFFFF;
      return r[23:0];
    endfunction

    // note an accepted input word and queue its result
    function void note_word(in_word_t w);
      out_word_t o;
      bit usable, rej;
      longint d, sc;
      logic [23:0] c;
      o = '0;
      case (opcode_e'(w.opcode))
        OP_CLEAR: begin
          npts = 0;
          flawed = 0;
          evals = 0;
        end
        OP_APPEND: begin
          rej = 0;
          if (npts >= MaxPoints) rej = 1;
          else if (npts > 0) begin
            if (!(w.point_command > cmd_tab[npts-1])) rej = 1;
            else if ({1'b0, w.point_reduction} + 25'd1 < {1'b0, red_tab[npts-1]}) rej = 1;
          end
          if (rej) begin
            flawed = 1;
            o.status = 1;
          end else begin
            cmd_tab[npts] = w.point_command;
            red_tab[npts] = w.point_reduction;
            npts++;
          end
        end
        OP_EVAL: begin
          usable = npts >= 2 && !flawed;
          evals = evals + 1;
          c = '0;
          if (w.envelope != 0 && !w.envelope[24]) begin
            d = (drive > FullDrive) ? 65536 : drive;
            sc = 65536 + 3 * d;
            c = 24'((longint'(w.envelope) * sc) >> 18);
            if (usable) begin
              if (c < cmd_tab[0]) c = cmd_tab[0];
              if (c > cmd_tab[npts-1]) c = cmd_tab[npts-1];
            end
          end
          o.command_volts = c;
          if (usable) o.reduction_db = interp(c);
        end
        default: ;
      endcase
      o.sample_index = evals;
      o.table_usable = npts >= 2 && !flawed;
      pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      mismatches++;
    endtask

    task check_word(out_word_t g);
      out_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (g.command_volts !== e.command_volts)
        report("command_volts", g.command_volts, e.command_volts);
      if (g.reduction_db !== e.reduction_db)
        report("reduction_db", g.reduction_db, e.reduction_db);
      if (g.sample_index !== e.sample_index)
        report("sample_index", g.sample_index, e.sample_index);
      if (g.table_usable !== e.table_usable)
        report("table_usable", g.table_usable, e.table_usable);
      if (g.status !== e.status) report("status", g.status, e.status);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  tgr_in_if in_if ();
  tgr_out_if out_if ();

  gain_table_board board = new;
  int hold_cycles = 0;
  bit no_stall = 0;
  int evals_seen = 0, appends_sent = 0;

  table_gain_reduction_interp uut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_if.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 0;
        hold_cycles--;
      end else if (no_stall || $urandom_range(0, 3) != 0) out_if.ready <= 1;
      else out_if.ready <= 0;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_if.valid && out_if.ready) board.check_word(out_if.data);

  always @(posedge clk_i)
    if (rst_ni && in_if.valid && in_if.ready) board.note_word(in_if.data);

  // valid stays up after the accepting edge until the next call or drain
  // replaces it at the same falling edge
  task automatic send_word(opcode_e op, logic [24:0] env, logic [23:0] pc, logic [23:0] pr,
                           bit gaps = 1);
    int g;
    g = gaps ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0) : 0;
    if (g > 0) begin
      in_if.valid <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid <= 1;
    in_if.data <= {op, env, pc, pr};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (op == OP_EVAL) evals_seen++;
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_drive(logic [16:0] v);
    drain();
    psel <= 1; pwrite <= 1; paddr <= 2'(RegDrive); pwdata <= 32'(v);
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.drive = v;
  endtask

  // ordered table of n points with random spacing
  task automatic build_table(int n);
    logic [23:0] c, r;
    send_word(OP_CLEAR, 0, 0, 0);
    c = 24'($urandom_range(0, 24'h3FFFF));
    r = 24'($urandom_range(0, 24'h3FFFF));
    for (int i = 0; i < n; i++) begin
      send_word(OP_APPEND, 25'($urandom), c, r);
      c = 24'(c + $urandom_range(1, 24'h3FFFF));
      r = ($urandom_range(0, 4) == 0) ? 24'(r - 24'd1) : 24'(r + $urandom_range(0, 24'h7FFFF));
    end
  endtask

  initial begin
    logic [16:0] drives[5];
    drives = '{17'd65536, 17'd0, 17'h1FFFF, 17'd32768, 17'h0ABCD};
    in_if.valid = 0;
    in_if.data = '0;
    board.reset_state();
    repeat (6) @(negedge clk_i);
    rst_ni = 1;

    // directed: evals on empty table, extremes, rejects, full table
    send_word(OP_EVAL, 25'h0FFFFFF, 0, 0);
    send_word(OP_EVAL, 25'h1000000, 0, 0);
    send_word(OP_EVAL, 0, 0, 0);
    send_word(OP_NONE, 25'h1FFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(OP_APPEND, 0, 24'h000000, 24'hFFFFFF);
    send_word(OP_EVAL, 25'h0000100, 0, 0);
    send_word(OP_APPEND, 0, 24'hFFFFFF, 24'hFFFFFE);
    send_word(OP_EVAL, 25'h0FFFFFF, 0, 0);
    send_word(OP_EVAL, 25'h1FFFFFF, 0, 0);
    send_word(OP_EVAL, 25'h0800000, 0, 0);
    send_word(OP_APPEND, 0, 24'hFFFFFF, 24'h0);
    send_word(OP_EVAL, 25'h0800000, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_APPEND, 0, 24'h100, 24'h500);
    send_word(OP_APPEND, 0, 24'h200, 24'h4FE);
    send_word(OP_APPEND, 0, 24'h300, 24'h4FF);
    send_word(OP_EVAL, 25'h280, 0, 0);
    for (int i = 0; i < MaxPoints + 1; i++)
      send_word(OP_APPEND, 0, 24'(i * 1000 + 5), 24'(i * 3), 0);
    send_word(OP_EVAL, 25'h3000, 0, 0);

    // pressure: long receiver hold-off while sender keeps going
    build_table(6);
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) send_word(OP_EVAL, 25'($urandom), 0, 0, 0);
    drain();

    // random phases across drive settings
    for (int p = 0; p < 5; p++) begin
      write_drive(drives[p]);
      no_stall = (p == 2);
      for (int t = 0; t < 10; t++) begin
        build_table((t % 4 == 0) ? $urandom_range(0, 64) : $urandom_range(2, 8));
        for (int k = 0; k < 16; k++) begin
          case ($urandom_range(0, 19))
            0: send_word(OP_APPEND, 25'($urandom), 24'($urandom), 24'($urandom));
            1: send_word(OP_NONE, 25'($urandom), 24'($urandom), 24'($urandom));
            2: send_word(OP_EVAL, 25'h1000000 | 25'($urandom), 0, 0);
            default: send_word(OP_EVAL, (k % 2) ? 25'($urandom_range(0, 24'h7FFFFF))
                                                 : 25'($urandom),
                               24'($urandom), 24'($urandom));
          endcase
        end
      end
    end
    no_stall = 0;
    drain();

    $display("covered %0d evaluations over 5 drive settings, table sizes 0 to 64,",
             evals_seen);
    $display("ordering rejects, full-table rejects and receiver hold-offs");
    if (board.mismatches == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* files.f */
hdl/tgr_pkg.sv
hdl/tgr_stream_if.sv
hdl/tgr_divider.sv
hdl/table_gain_reduction_interp.sv
tb/sv/table_gain_reduction_interp_tb.sv
